>>> src/ghf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghf_pkg - shared constants and helpers for the track heading fit
// Fixed-point limits, angle constants in Q6.30, the arctangent table and
// the sign, magnitude and saturating helpers used by the sequencer.
// ----------------------------------------------------------------------------
package ghf_pkg;

  localparam int MAX_FIXES    = 64;
  localparam int CORDIC_STEPS = 24;
  localparam int KEPT_W       = $clog2(MAX_FIXES + 1);

  localparam logic signed [63:0] LIM64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] LIM48 = 64'sd140737488355327;
  localparam logic signed [63:0] LIM34 = 64'sd8589934591;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [63:0] GAIN_INV_Q30 = 64'sd652032874;

  localparam logic [63:0] LAT_TO_RAD_Q62 = 64'd8048910509;
  localparam logic [63:0] RAD_TO_CD_Q48  = 64'd1501974482;

  // Normalization window for the vectoring input
  localparam logic [63:0] NORM_HI = 64'd1 << 40;
  localparam logic [63:0] NORM_LO = 64'd1 << 39;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
    30'h00000001, 30'h00000000
  };

  // Magnitude of a value that never reaches the most negative code
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Restore a sign onto a magnitude
  function automatic logic signed [63:0] sgn64(input logic neg, input logic [63:0] m);
    sgn64 = neg ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to +-lim
  function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
    if (v > lim) clamp_lim = lim;
    else if (v < -lim) clamp_lim = -lim;
    else clamp_lim = v;
  endfunction

  // Saturating add at +-(2^63-1)
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(LIM64)) sadd64 = LIM64;
    else if (s < -65'(LIM64)) sadd64 = -LIM64;
    else sadd64 = s[63:0];
  endfunction

endpackage

>>> src/gps_track_heading_fit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_track_heading_fit_unit - principal-axis heading of a run of GPS fixes
// Drops leading fixes, turns kept fixes into local offsets, keeps running
// sums and at the closing fix computes the compass heading in centidegrees.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | request   | tdata[30:0] latitude, tdata[62:31] longitude,
//          |           | tlast last_fix
//  out_    | result    | tdata[15:0] heading_centideg, tuser fit_valid
//  cfg_    | write     | wr_data leading fixes to drop per run
//
// One shared shift-add multiplier and one shared CORDIC slice (one step per
// cycle, 24 steps) do all the arithmetic. A dropped fix does none; the
// first kept fix takes one product and one CORDIC pass, every later kept
// fix four products. The closing fix adds the fit: nine products, two
// CORDIC passes and up to 39 normalize shifts; a single pass with zero
// spread, and no fit when fewer than two fixes were kept.
// in_tready is high only while idle. A finished result waits in the output
// register; the next fix is taken meanwhile. No clearing pass after reset.
// ----------------------------------------------------------------------------
module gps_track_heading_fit_unit
  import ghf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [30:0] latitude, [62:31] longitude
  input  logic        in_tlast,   // last_fix
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] heading_centideg
  output logic        out_tuser,  // [0] fit_valid
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_MUL, S_CORD, S_COS_ANG, S_COS_DONE,
    S_X_DONE, S_XX_DONE, S_YY_DONE, S_XY_DONE,
    S_FIT, F_XX1, F_XX2, F_YY1, F_YY2, F_XY1, F_XY2,
    S_ATAN, S_NORM, S_TH, S_DOT1, S_DOT2, S_HEAD, S_CD, S_EMIT
  } state_t;

  state_t state_r, ret_r;

  logic [5:0]  skip_r;
  logic [7:0]  fix_count_r;
  logic [KEPT_W-1:0] kept_r;
  logic signed [30:0] lat_r, ref_lat_r;
  logic signed [31:0] lon_r, ref_lon_r, ref_cos_r;
  logic        last_r;
  logic signed [47:0] sum_x_r, sum_y_r;
  logic signed [63:0] sum_xx_r, sum_yy_r, sum_xy_r;
  logic signed [33:0] last_x_r, last_y_r;

  // shared multiplier
  logic [63:0]  mul_a_r, mul_b_r;
  logic         mul_neg_r;
  logic [127:0] prod_r;
  logic [5:0]   mcnt_r;

  // shared CORDIC / normalize registers
  logic signed [63:0] cx_r, cy_r;
  logic signed [35:0] cz_r, th_r;
  logic [4:0]  cstep_r;
  logic        vec_r, flip_r;
  logic signed [63:0] dot_r;

  logic [15:0] head_r;
  logic        fitv_r;
  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic        out_tuser_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Multiplier step: add multiplicand on the low multiplier bit, shift right
  logic [64:0] mul_sum;
  assign mul_sum = {1'b0, prod_r[127:64]} + (mul_b_r[0] ? {1'b0, mul_a_r} : 65'd0);

  // Product views: saturated, plain signed and rounded
  logic [63:0] sat_mag, rnd30, rnd32, rnd48;
  logic signed [63:0] smul_val, prod_val;
  assign sat_mag  = (|prod_r[127:63]) ? 64'(LIM64) : {1'b0, prod_r[62:0]};
  assign smul_val = sgn64(mul_neg_r, sat_mag);
  assign prod_val = sgn64(mul_neg_r, prod_r[63:0]);
  assign rnd30 = (prod_r[63:0] + (64'd1 << 29)) >> 30;
  assign rnd32 = (prod_r[63:0] + (64'd1 << 31)) >> 32;
  assign rnd48 = (prod_r[63:0] + (64'd1 << 47)) >> 48;

  // Local offsets of the current fix
  logic signed [32:0] dlon;
  logic signed [31:0] dlat;
  logic signed [63:0] x_val;
  assign dlon  = 33'(lon_r) - 33'(ref_lon_r);
  assign dlat  = 32'(lat_r) - 32'(ref_lat_r);
  assign x_val = clamp_lim(sgn64(mul_neg_r, rnd30), LIM34);

  // CORDIC slice
  logic signed [63:0] cord_dx, cord_dy;
  logic signed [35:0] cord_at;
  logic               cord_pos;
  assign cord_dx  = cy_r >>> cstep_r;
  assign cord_dy  = cx_r >>> cstep_r;
  assign cord_at  = $signed({6'd0, ATAN_TAB[cstep_r]});
  assign cord_pos = vec_r ? cy_r[63] : !cz_r[35];

  // Vectoring input: 2*Cxy saturated and Cxx - Cyy
  logic signed [63:0] vec_y, vec_x;
  assign vec_y = (mag64(sum_xy_r) >= (64'd1 << 62)) ? (sum_xy_r[63] ? -LIM64 : LIM64)
                                                    : (sum_xy_r <<< 1);
  assign vec_x = sadd64(sum_xx_r, -sum_yy_r);

  logic [63:0] norm_m;
  assign norm_m = (mag64(cx_r) > mag64(cy_r)) ? mag64(cx_r) : mag64(cy_r);

  // Cosine argument
  logic signed [35:0] cos_ang;
  assign cos_ang = $signed({4'd0, rnd32[31:0]});

  // Direction turn and heading fold
  logic signed [63:0] dot_sum, c4, s4;
  logic signed [35:0] th_turn, h0, h1, h_fold;
  assign c4      = cx_r >>> 2;
  assign s4      = cy_r >>> 2;
  assign dot_sum = dot_r + prod_val;
  assign th_turn = dot_sum[63] ? th_r + PI_Q30 : th_r;
  assign h0      = HALF_PI_Q30 - th_turn;
  assign h1      = (h0 >= PI_Q30) ? h0 - TWO_PI_Q30 : h0;
  assign h_fold  = (h1 < -PI_Q30) ? h1 + TWO_PI_Q30 : h1;

  logic signed [63:0] cd_full;
  logic signed [17:0] cd0, cd1, cd_fold;
  assign cd_full = sgn64(mul_neg_r, rnd48);
  assign cd0     = cd_full[17:0];
  assign cd1     = (cd0 >= 18'sd18000) ? cd0 - 18'sd36000 : cd0;
  assign cd_fold = (cd1 < -18'sd18000) ? cd1 + 18'sd36000 : cd1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      skip_r       <= 6'd10;
      fix_count_r  <= '0;
      kept_r       <= '0;
      ref_lat_r    <= '0;
      ref_lon_r    <= '0;
      ref_cos_r    <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_xx_r     <= '0;
      sum_yy_r     <= '0;
      sum_xy_r     <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
      // drop the taken result unless a new one replaces it this cycle
      if (out_tvalid_r && out_tready && state_r != S_EMIT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lat_r   <= $signed(in_tdata[30:0]);
            lon_r   <= $signed(in_tdata[62:31]);
            last_r  <= in_tlast;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (kept_r == '0 && fix_count_r < 8'(skip_r)) begin
            fix_count_r <= fix_count_r + 8'd1;
            state_r     <= last_r ? S_FIT : S_IDLE;
          end else if (kept_r == '0) begin
            ref_lat_r <= lat_r;
            ref_lon_r <= lon_r;
            mul_a_r   <= mag64(64'(lat_r));
            mul_b_r   <= LAT_TO_RAD_Q62;
            mul_neg_r <= 1'b0;
            prod_r    <= '0;
            mcnt_r    <= '0;
            ret_r     <= S_COS_ANG;
            state_r   <= S_MUL;
          end else if (kept_r < KEPT_W'(MAX_FIXES)) begin
            mul_a_r   <= mag64(64'(dlon));
            mul_b_r   <= mag64(64'(ref_cos_r));
            mul_neg_r <= dlon[32] ^ ref_cos_r[31];
            prod_r    <= '0;
            mcnt_r    <= '0;
            ret_r     <= S_X_DONE;
            state_r   <= S_MUL;
          end else begin
            state_r <= last_r ? S_FIT : S_IDLE;
          end
        end
        // advance the shift-add multiplier one bit
        S_MUL: begin
          prod_r  <= {mul_sum, prod_r[63:1]};
          mul_b_r <= mul_b_r >> 1;
          mcnt_r  <= mcnt_r + 6'd1;
          if (mcnt_r == 6'd63) begin
            state_r <= ret_r;
          end
        end
        // advance one CORDIC step
        S_CORD: begin
          if (cord_pos) begin
            cx_r <= cx_r - cord_dx;
            cy_r <= cy_r + cord_dy;
            cz_r <= cz_r - cord_at;
          end else begin
            cx_r <= cx_r + cord_dx;
            cy_r <= cy_r - cord_dy;
            cz_r <= cz_r + cord_at;
          end
          cstep_r <= cstep_r + 5'd1;
          if (cstep_r == 5'(CORDIC_STEPS - 1)) begin
            state_r <= ret_r;
          end
        end
        // fold the reference angle into the first quadrant
        S_COS_ANG: begin
          if (cos_ang > HALF_PI_Q30) begin
            cz_r   <= PI_Q30 - cos_ang;
            flip_r <= 1'b1;
          end else begin
            cz_r   <= cos_ang;
            flip_r <= 1'b0;
          end
          cx_r    <= GAIN_INV_Q30;
          cy_r    <= '0;
          cstep_r <= '0;
          vec_r   <= 1'b0;
          ret_r   <= S_COS_DONE;
          state_r <= S_CORD;
        end
        S_COS_DONE: begin
          ref_cos_r <= flip_r ? -cx_r[31:0] : cx_r[31:0];
          kept_r    <= KEPT_W'(1);
          state_r   <= last_r ? S_FIT : S_IDLE;
        end
        // accumulate offsets, then the three products
        S_X_DONE: begin
          last_x_r  <= x_val[33:0];
          last_y_r  <= 34'(dlat);
          sum_x_r   <= 48'(clamp_lim(64'(sum_x_r) + x_val, LIM48));
          sum_y_r   <= 48'(clamp_lim(64'(sum_y_r) + 64'(dlat), LIM48));
          mul_a_r   <= mag64(x_val);
          mul_b_r   <= mag64(x_val);
          mul_neg_r <= 1'b0;
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_XX_DONE;
          state_r   <= S_MUL;
        end
        S_XX_DONE: begin
          sum_xx_r  <= sadd64(sum_xx_r, smul_val);
          mul_a_r   <= mag64(64'(last_y_r));
          mul_b_r   <= mag64(64'(last_y_r));
          mul_neg_r <= 1'b0;
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_YY_DONE;
          state_r   <= S_MUL;
        end
        S_YY_DONE: begin
          sum_yy_r  <= sadd64(sum_yy_r, smul_val);
          mul_a_r   <= mag64(64'(last_x_r));
          mul_b_r   <= mag64(64'(last_y_r));
          mul_neg_r <= last_x_r[33] ^ last_y_r[33];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_XY_DONE;
          state_r   <= S_MUL;
        end
        S_XY_DONE: begin
          sum_xy_r <= sadd64(sum_xy_r, smul_val);
          kept_r   <= kept_r + KEPT_W'(1);
          state_r  <= last_r ? S_FIT : S_IDLE;
        end
        // n-scaled covariance, one product at a time
        S_FIT: begin
          if (kept_r < KEPT_W'(2)) begin
            head_r  <= '0;
            fitv_r  <= 1'b0;
            state_r <= S_EMIT;
          end else begin
            mul_a_r   <= 64'(kept_r);
            mul_b_r   <= mag64(sum_xx_r);
            mul_neg_r <= sum_xx_r[63];
            prod_r    <= '0;
            mcnt_r    <= '0;
            ret_r     <= F_XX1;
            state_r   <= S_MUL;
          end
        end
        F_XX1: begin
          sum_xx_r  <= smul_val;
          mul_a_r   <= mag64(64'(sum_x_r));
          mul_b_r   <= mag64(64'(sum_x_r));
          mul_neg_r <= 1'b0;
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= F_XX2;
          state_r   <= S_MUL;
        end
        F_XX2: begin
          sum_xx_r  <= sadd64(sum_xx_r, -smul_val);
          mul_a_r   <= 64'(kept_r);
          mul_b_r   <= mag64(sum_yy_r);
          mul_neg_r <= sum_yy_r[63];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= F_YY1;
          state_r   <= S_MUL;
        end
        F_YY1: begin
          sum_yy_r  <= smul_val;
          mul_a_r   <= mag64(64'(sum_y_r));
          mul_b_r   <= mag64(64'(sum_y_r));
          mul_neg_r <= 1'b0;
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= F_YY2;
          state_r   <= S_MUL;
        end
        F_YY2: begin
          sum_yy_r  <= sadd64(sum_yy_r, -smul_val);
          mul_a_r   <= 64'(kept_r);
          mul_b_r   <= mag64(sum_xy_r);
          mul_neg_r <= sum_xy_r[63];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= F_XY1;
          state_r   <= S_MUL;
        end
        F_XY1: begin
          sum_xy_r  <= smul_val;
          mul_a_r   <= mag64(64'(sum_x_r));
          mul_b_r   <= mag64(64'(sum_y_r));
          mul_neg_r <= sum_x_r[47] ^ sum_y_r[47];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= F_XY2;
          state_r   <= S_MUL;
        end
        F_XY2: begin
          sum_xy_r <= sadd64(sum_xy_r, -smul_val);
          state_r  <= S_ATAN;
        end
        // load the vectoring input; zero spread gives a zero angle
        S_ATAN: begin
          cx_r <= vec_x;
          cy_r <= vec_y;
          if (vec_x == '0 && vec_y == '0) begin
            cz_r    <= '0;
            state_r <= S_TH;
          end else begin
            state_r <= S_NORM;
          end
        end
        // shift into the normalize window, then fold to the right half-plane
        S_NORM: begin
          if (norm_m >= NORM_HI) begin
            cx_r <= cx_r >>> 1;
            cy_r <= cy_r >>> 1;
          end else if (norm_m < NORM_LO) begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
          end else begin
            if (cx_r[63]) begin
              if (!cy_r[63]) begin
                cx_r <= cy_r;
                cy_r <= -cx_r;
                cz_r <= HALF_PI_Q30;
              end else begin
                cx_r <= -cy_r;
                cy_r <= cx_r;
                cz_r <= -HALF_PI_Q30;
              end
            end else begin
              cz_r <= '0;
            end
            cstep_r <= '0;
            vec_r   <= 1'b1;
            ret_r   <= S_TH;
            state_r <= S_CORD;
          end
        end
        // halve the angle and rotate the unit vector onto the axis
        S_TH: begin
          th_r    <= cz_r >>> 1;
          cz_r    <= cz_r >>> 1;
          cx_r    <= GAIN_INV_Q30;
          cy_r    <= '0;
          cstep_r <= '0;
          vec_r   <= 1'b0;
          ret_r   <= S_DOT1;
          state_r <= S_CORD;
        end
        S_DOT1: begin
          mul_a_r   <= mag64(64'(last_x_r));
          mul_b_r   <= mag64(c4);
          mul_neg_r <= last_x_r[33] ^ c4[63];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_DOT2;
          state_r   <= S_MUL;
        end
        S_DOT2: begin
          dot_r     <= prod_val;
          mul_a_r   <= mag64(64'(last_y_r));
          mul_b_r   <= mag64(s4);
          mul_neg_r <= last_y_r[33] ^ s4[63];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_HEAD;
          state_r   <= S_MUL;
        end
        // turn against the motion, convert to compass angle
        S_HEAD: begin
          mul_a_r   <= mag64(64'(h_fold));
          mul_b_r   <= RAD_TO_CD_Q48;
          mul_neg_r <= h_fold[35];
          prod_r    <= '0;
          mcnt_r    <= '0;
          ret_r     <= S_CD;
          state_r   <= S_MUL;
        end
        S_CD: begin
          head_r  <= cd_fold[15:0];
          fitv_r  <= 1'b1;
          state_r <= S_EMIT;
        end
        // hold until the output register frees, then clear the run
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= head_r;
            out_tuser_r  <= fitv_r;
            fix_count_r  <= '0;
            kept_r       <= '0;
            ref_lat_r    <= '0;
            ref_lon_r    <= '0;
            ref_cos_r    <= '0;
            sum_x_r      <= '0;
            sum_y_r      <= '0;
            sum_xx_r     <= '0;
            sum_yy_r     <= '0;
            sum_xy_r     <= '0;
            last_x_r     <= '0;
            last_y_r     <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
